[hdl/vno2d_pkg.sv]
// Package for the fractal 2-D value noise block: field widths, fixed-point
// constants, the pipeline stage count and the register map.
// No dependencies.
package vno2d_pkg;

   // Port field widths.
   localparam int COORD_W = 30;
   localparam int OUT_W   = 31;
   localparam int PERS_W  = 17;
   localparam int AMP_W   = 17;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Fixed-point constants.
   localparam int FRAC_W     = 16;
   localparam int ONE_Q16    = 65536;
   localparam int FRAC_MASK  = 65535;
   localparam int OUT_LIMIT  = 805306368;
   localparam int SHIFT_RAW  = 18;
   localparam int SHIFT_SCAL = 20;
   localparam int PERS_RESET = 32768;

   // Hash constants.
   localparam logic [31:0] HASH_MUL  = 32'd15731;
   localparam logic [31:0] HASH_ADD1 = 32'd789221;
   localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
   localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;
   localparam logic [31:0] LAT_ONE   = 32'h4000_0000;
   localparam logic [31:0] ROW_MUL   = 32'd57;

   // Internal widths; the scaled coordinate covers frequencies up to 2^7.
   localparam int XS_W  = COORD_W + 7;
   localparam int IDX_W = 32;
   localparam int FX_W  = FRAC_W + 1;
   localparam int WT_W  = FRAC_W + 2;
   localparam int LAT_W = 32;
   localparam int SM_W  = 33;
   localparam int PRD_W = 51;
   localparam int R_W   = 33;
   localparam int O_W   = 36;
   localparam int WGT_W = 54;
   localparam int SUM_W = 58;

   // Register stages from the input register to the result register.
   localparam int STAGES = 15;

   typedef logic [STAGES-1:0] stage_vec_type;

   // Register index decoded from the address.
   typedef enum logic {
      REG_PERSISTENCE = 1'b0,
      REG_SCALED_MODE = 1'b1
   } csr_reg_type;

endpackage

[hdl/value_noise_2d_octaves.sv]
// Fractal 2-D value noise over OCTAVES octaves at frequencies 1, 2, 4 and up.
// Point (x, y) in signed Q14.16 enters on the req_ channel with valid and
// ready; the summed noise leaves in signed Q3.28 on the rsp_ channel.
// The user must write persistence and scaled mode over the APB-style port
// only while no transaction is in flight; the block does not enforce this.
// The pipeline takes one transaction per cycle while the result register is
// not stalled: every octave lane owns sixteen hash units, one per lattice
// point of its 4x4 window, and each stage holds one point.
// Each stage carries a valid bit and advances when the stage after it is
// empty or advancing, so bubbles close up and req_ready drops only when all
// stages hold data and the receiver stalls the result register.
// Amplitudes follow a persistence write through the chain of amplitude registers.
// Reset clears all valid bits and sets persistence to one half and scaled
// mode to zero.
// Depends on vno2d_pkg and vno2d_octave.
module value_noise_2d_octaves import vno2d_pkg::*; #(
   parameter int OCTAVES = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_x_coord,
   input  logic signed [COORD_W-1:0] req_y_coord,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [OUT_W-1:0]   rsp_noise_value,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   // Configuration registers.
   logic [PERS_W-1:0] persistence_ff;
   logic              scaled_mode_ff;
   logic              csr_write;
   csr_reg_type       csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         persistence_ff <= PERS_W'(PERS_RESET);
         scaled_mode_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_PERSISTENCE: persistence_ff <= pwdata[PERS_W-1:0];
            REG_SCALED_MODE: scaled_mode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_PERSISTENCE: prdata = CSR_DATA_W'(persistence_ff);
         REG_SCALED_MODE: prdata = CSR_DATA_W'(scaled_mode_ff);
         default:         prdata = '0;
      endcase
   end

   // Octave amplitudes, persistence clamped to one.
   logic [AMP_W-1:0] pers_clamp;
   logic [AMP_W-1:0] amp_ff [OCTAVES];

   assign pers_clamp = (persistence_ff > PERS_W'(ONE_Q16)) ? AMP_W'(ONE_Q16)
                                                            : persistence_ff;
   assign amp_ff[0]  = AMP_W'(ONE_Q16);

   for (genvar k = 1; k < OCTAVES; k++) begin : g_amp
      always_ff @(posedge clock) begin
         if (reset) begin
            amp_ff[k] <= '0;
         end else begin
            amp_ff[k] <= AMP_W'(((2*AMP_W)'(amp_ff[k-1]) * (2*AMP_W)'(pers_clamp))
                                >> FRAC_W);
         end
      end
   end

   // Stage valid bits and advance enables.
   logic [STAGES-1:0] v_ff;
   stage_vec_type     stage_en;

   always_comb begin
      stage_en[STAGES-1] = !v_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !v_ff[i] || stage_en[i+1];
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = v_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (stage_en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Stage 0: input register.
   logic signed [COORD_W-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff <= req_x_coord;
         y_ff <= req_y_coord;
      end
   end

   // Stages 1 to 12: one lane per octave.
   logic signed [WGT_W-1:0] weighted [OCTAVES];

   for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
      vno2d_octave #(
         .OCT_SHIFT(k)
      ) u_octave (
         .clock    (clock),
         .stage_en (stage_en),
         .x_coord  (x_ff),
         .y_coord  (y_ff),
         .amp      (amp_ff[k]),
         .weighted (weighted[k])
      );
   end

   // Stage 13: sum of the weighted octaves.
   logic signed [SUM_W-1:0] sum_next, sum_ff;

   always_comb begin
      sum_next = '0;
      for (int k = 0; k < OCTAVES; k++) begin
         sum_next = sum_next + SUM_W'(weighted[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[13]) begin
         sum_ff <= sum_next;
      end
   end

   // Stage 14: scale toward zero, saturate and hold the result.
   logic              sum_neg;
   logic [SUM_W-1:0]  sum_mag, sum_shift;
   logic [OUT_W-1:0]  clip;
   logic signed [OUT_W-1:0] rsp_ff;

   assign sum_neg   = sum_ff[SUM_W-1];
   assign sum_mag   = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign sum_shift = scaled_mode_ff ? (sum_mag >> SHIFT_SCAL) : (sum_mag >> SHIFT_RAW);
   assign clip      = (sum_shift > SUM_W'(OUT_LIMIT)) ? OUT_W'(OUT_LIMIT)
                                                      : sum_shift[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[14]) begin
         rsp_ff <= sum_neg ? -clip : clip;
      end
   end

   assign rsp_noise_value = rsp_ff;

`ifndef SYNTHESIS
   // The result never leaves the saturation range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_noise_value <= OUT_W'(OUT_LIMIT)) &&
                    (rsp_noise_value >= -OUT_W'(OUT_LIMIT)))
      else $error("noise result outside saturation range");

   // Input back-pressure only comes from a stalled, full pipeline.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&v_ff) && !rsp_ready)
      else $error("req_ready low without a full stalled pipeline");

   // A new result comes from the summing stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v_ff[STAGES-2]))
      else $error("result valid without a summed transaction");
`endif

endmodule

[hdl/vno2d_octave.sv]
// One octave lane of the value noise pipeline, stages one to twelve: lattice
// hashing, 3x3 smoothing, bilinear blend and amplitude weighting.
// Depends on vno2d_pkg.
module vno2d_octave import vno2d_pkg::*; #(
   parameter int unsigned OCT_SHIFT = 0
) (
   input  logic                      clock,
   input  stage_vec_type             stage_en,
   input  logic signed [COORD_W-1:0] x_coord,
   input  logic signed [COORD_W-1:0] y_coord,
   input  logic        [AMP_W-1:0]   amp,
   output logic signed [WGT_W-1:0]   weighted
);

   // Divide by 65536 with truncation toward zero.
   function automatic logic signed [O_W-1:0] trunc16(input logic signed [PRD_W:0] s);
      logic signed [PRD_W:0] adj;
      adj = s + (s[PRD_W] ? (PRD_W+1)'(FRAC_MASK) : '0);
      return O_W'(adj >>> FRAC_W);
   endfunction

   // Stage 1: scale the point and split it into integer and fraction parts.
   logic signed [XS_W-1:0] xs, ys, xadj, yadj, xint, yint, xfr, yfr;
   logic [IDX_W-1:0] ix_ff, iy_ff;
   logic signed [FX_W-1:0] fx_ff [1:9];
   logic signed [FX_W-1:0] fy_ff [1:9];

   assign xs   = XS_W'(x_coord) <<< OCT_SHIFT;
   assign ys   = XS_W'(y_coord) <<< OCT_SHIFT;
   assign xadj = xs + (xs[XS_W-1] ? XS_W'(FRAC_MASK) : '0);
   assign yadj = ys + (ys[XS_W-1] ? XS_W'(FRAC_MASK) : '0);
   assign xint = xadj >>> FRAC_W;
   assign yint = yadj >>> FRAC_W;
   assign xfr  = xs - (xint <<< FRAC_W);
   assign yfr  = ys - (yint <<< FRAC_W);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         ix_ff    <= IDX_W'(xint);
         iy_ff    <= IDX_W'(yint);
         fx_ff[1] <= xfr[FX_W-1:0];
         fy_ff[1] <= yfr[FX_W-1:0];
      end
   end

   // The fractions travel beside the data until the blends use them.
   always_ff @(posedge clock) begin
      for (int i = 2; i <= 9; i++) begin
         if (stage_en[i]) begin
            fx_ff[i] <= fx_ff[i-1];
            fy_ff[i] <= fy_ff[i-1];
         end
      end
   end

   // Stage 2: hash base index of the cell.
   logic [IDX_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         base_ff <= ix_ff + 32'(iy_ff * ROW_MUL);
      end
   end

   // Stages 3 to 6: hash all sixteen lattice points of the 4x4 window.
   logic [31:0] n3_ff [4][4];
   logic [31:0] n4_ff [4][4];
   logic [31:0] n5_ff [4][4];
   logic [31:0] sq_ff [4][4];
   logic [31:0] t_ff  [4][4];
   logic signed [LAT_W-1:0] lat_ff [4][4];

   for (genvar gx = 0; gx < 4; gx++) begin : g_hx
      for (genvar gy = 0; gy < 4; gy++) begin : g_hy
         localparam int OFF = (gx - 1) + 57 * (gy - 1);
         logic [31:0] m;
         logic [31:0] h;

         assign m = base_ff + 32'(OFF);
         assign h = (n5_ff[gx][gy] * t_ff[gx][gy] + HASH_ADD2) & HASH_MASK;

         always_ff @(posedge clock) begin
            if (stage_en[3]) begin
               n3_ff[gx][gy] <= m ^ (m << 13);
            end
            if (stage_en[4]) begin
               sq_ff[gx][gy] <= n3_ff[gx][gy] * n3_ff[gx][gy];
               n4_ff[gx][gy] <= n3_ff[gx][gy];
            end
            if (stage_en[5]) begin
               t_ff[gx][gy]  <= sq_ff[gx][gy] * HASH_MUL + HASH_ADD1;
               n5_ff[gx][gy] <= n4_ff[gx][gy];
            end
            if (stage_en[6]) begin
               lat_ff[gx][gy] <= LAT_ONE - h;
            end
         end
      end
   end

   // Stage 7: smoothed values at the four cell corners.
   logic signed [SM_W-1:0] sm_ff [2][2];

   for (genvar a = 0; a < 2; a++) begin : g_sa
      for (genvar b = 0; b < 2; b++) begin : g_sb
         logic signed [LAT_W+1:0] corners, sides, centre, total;

         assign corners = (LAT_W+2)'(lat_ff[a][b])   + (LAT_W+2)'(lat_ff[a+2][b])
                        + (LAT_W+2)'(lat_ff[a][b+2]) + (LAT_W+2)'(lat_ff[a+2][b+2]);
         assign sides   = (LAT_W+2)'(lat_ff[a][b+1])   + (LAT_W+2)'(lat_ff[a+2][b+1])
                        + (LAT_W+2)'(lat_ff[a+1][b])   + (LAT_W+2)'(lat_ff[a+1][b+2]);
         assign centre  = (LAT_W+2)'(lat_ff[a+1][b+1]);
         assign total   = (corners >>> 4) + (sides >>> 3) + (centre >>> 2);

         always_ff @(posedge clock) begin
            if (stage_en[7]) begin
               sm_ff[a][b] <= SM_W'(total);
            end
         end
      end
   end

   // Stages 8 and 9: blend along x for the lower and upper rows.
   logic signed [WT_W-1:0]  wx, wy, fxw, fyw;
   logic signed [PRD_W-1:0] pa0_ff, pb0_ff, pa1_ff, pb1_ff, q0_ff, q1_ff;
   logic signed [R_W-1:0]   r0_ff, r1_ff;
   logic signed [O_W-1:0]   r0_full, r1_full, o_full;
   logic signed [O_W-1:0]   o_ff;
   logic signed [WGT_W-1:0] w_ff;

   assign fxw = WT_W'(fx_ff[7]);
   assign wx  = WT_W'(ONE_Q16) - fxw;

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         pa0_ff <= sm_ff[0][0] * wx;
         pb0_ff <= sm_ff[1][0] * fxw;
         pa1_ff <= sm_ff[0][1] * wx;
         pb1_ff <= sm_ff[1][1] * fxw;
      end
   end

   assign r0_full = trunc16((PRD_W+1)'(pa0_ff) + (PRD_W+1)'(pb0_ff));
   assign r1_full = trunc16((PRD_W+1)'(pa1_ff) + (PRD_W+1)'(pb1_ff));

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         r0_ff <= R_W'(r0_full);
         r1_ff <= R_W'(r1_full);
      end
   end

   // Stages 10 and 11: blend along y.
   assign fyw = WT_W'(fy_ff[9]);
   assign wy  = WT_W'(ONE_Q16) - fyw;

   always_ff @(posedge clock) begin
      if (stage_en[10]) begin
         q0_ff <= r0_ff * wy;
         q1_ff <= r1_ff * fyw;
      end
   end

   assign o_full = trunc16((PRD_W+1)'(q0_ff) + (PRD_W+1)'(q1_ff));

   always_ff @(posedge clock) begin
      if (stage_en[11]) begin
         o_ff <= o_full;
      end
   end

   // Stage 12: weight the octave by its amplitude.
   always_ff @(posedge clock) begin
      if (stage_en[12]) begin
         w_ff <= o_ff * $signed({1'b0, amp});
      end
   end

   assign weighted = w_ff;

endmodule

[verif/value_noise_2d_octaves_checker.sv]
// Checker for the fractal 2-D value noise block: it watches the request,
// response and register ports, predicts every noise value and compares.
// Depends on vno2d_pkg.
module value_noise_2d_octaves_checker import vno2d_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_x_coord,
   input  logic signed [COORD_W-1:0] req_y_coord,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [OUT_W-1:0]   rsp_noise_value,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   input  logic                      pready,
   output int                        fail_count,
   output int                        pending
);

   localparam int NUM_OCTAVES = 3;

   logic [PERS_W-1:0]          persistence_q;
   logic                       scaled_q;
   logic signed [OUT_W-1:0]    noise_queue[$];

   // Lattice hash mapped to a Q1.30 value; indices wrap at 32 bits.
   function automatic longint lattice(longint ix, longint iy);
      logic [31:0] n;
      logic [31:0] h;
      n = ix[31:0] + iy[31:0] * ROW_MUL;
      n = (n << 13) ^ n;
      h = (n * (n * n * HASH_MUL + HASH_ADD1) + HASH_ADD2) & HASH_MASK;
      return longint'(LAT_ONE) - longint'(h);
   endfunction

   // 3x3 smoothing; >>> on a signed value rounds toward minus infinity.
   function automatic longint smoothed(longint ix, longint iy);
      longint corners;
      longint sides;
      corners = lattice(ix - 1, iy - 1) + lattice(ix + 1, iy - 1)
              + lattice(ix - 1, iy + 1) + lattice(ix + 1, iy + 1);
      sides = lattice(ix - 1, iy) + lattice(ix + 1, iy)
            + lattice(ix, iy - 1) + lattice(ix, iy + 1);
      return (corners >>> 4) + (sides >>> 3) + (lattice(ix, iy) >>> 2);
   endfunction

   // Linear blend with a signed Q0.16 fraction, truncated toward zero.
   function automatic longint lerp16(longint a, longint b, longint f);
      return (a * (ONE_Q16 - f) + b * f) / ONE_Q16;
   endfunction

   function automatic longint octave(longint xs, longint ys);
      longint ix;
      longint iy;
      longint fx;
      longint fy;
      ix = xs / ONE_Q16;
      iy = ys / ONE_Q16;
      fx = xs - ix * ONE_Q16;
      fy = ys - iy * ONE_Q16;
      return lerp16(lerp16(smoothed(ix, iy), smoothed(ix + 1, iy), fx),
                    lerp16(smoothed(ix, iy + 1), smoothed(ix + 1, iy + 1), fx), fy);
   endfunction

   // Weighted octave sum, shifted toward zero and saturated to +-3.0.
   function automatic logic signed [OUT_W-1:0] fractal_noise(
      longint x, longint y, logic [PERS_W-1:0] pers, logic scaled);
      longint p;
      longint amp;
      longint total;
      longint res;
      int     shift;
      p = (pers > ONE_Q16) ? ONE_Q16 : longint'(pers);
      amp = ONE_Q16;
      total = 0;
      for (int k = 0; k < NUM_OCTAVES; k++) begin
         total += octave(x * (longint'(1) << k), y * (longint'(1) << k)) * amp;
         amp = (amp * p) >> 16;
      end
      shift = scaled ? SHIFT_SCAL : SHIFT_RAW;
      if (total >= 0) begin
         res = total >> shift;
      end else begin
         res = -((-total) >> shift);
      end
      if (res > OUT_LIMIT) res = OUT_LIMIT;
      if (res < -OUT_LIMIT) res = -OUT_LIMIT;
      return res[OUT_W-1:0];
   endfunction

   assign pending = noise_queue.size();

   // Track registers, predict on each request and compare on each response.
   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      if (reset) begin
         persistence_q <= PERS_W'(PERS_RESET);
         scaled_q      <= 1'b0;
         noise_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (csr_reg_type'(paddr[2]) == REG_PERSISTENCE) begin
               persistence_q <= pwdata[PERS_W-1:0];
            end else begin
               scaled_q <= pwdata[0];
            end
         end
         if (req_valid && req_ready) begin
            noise_queue.push_back(fractal_noise(req_x_coord, req_y_coord,
                                                persistence_q, scaled_q));
         end
         if (rsp_valid && rsp_ready) begin
            if (noise_queue.size() == 0) begin
               $display("%0t: unexpected transaction, noise_value %0d", $time,
                        rsp_noise_value);
               fail_count++;
            end else begin
               want = noise_queue.pop_front();
               if (want !== rsp_noise_value) begin
                  $display("%0t: noise_value expected %0d actual %0d", $time, want,
                           rsp_noise_value);
                  fail_count++;
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

[verif/value_noise_2d_octaves_tb.sv]
// Testbench top for the fractal 2-D value noise block: drives points and
// register writes under random idling and gives the verdict.
// Depends on vno2d_pkg, value_noise_2d_octaves and its checker.
module value_noise_2d_octaves_tb import vno2d_pkg::*;;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_x_coord;
   logic signed [COORD_W-1:0] req_y_coord;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [OUT_W-1:0]   rsp_noise_value;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_W-1:0]     paddr;
   logic [CSR_DATA_W-1:0]     pwdata;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;
   int                        fail_count;
   int                        pending;
   int                        phase;
   logic                      busy_burst;

   value_noise_2d_octaves u_dut (.*);

   value_noise_2d_octaves_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, a few long ones, none at all during a burst.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (busy_burst || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random stalls, plus one long hold-off that fills the pipeline.
   initial begin
      int hold;
      bit held_once;
      logic nxt;
      hold = 0;
      held_once = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            nxt = 1'b0;
         end else if (!held_once && phase == 2) begin
            held_once = 1;
            hold = 300;
            nxt = 1'b0;
         end else if (gap_length() > 0) begin
            hold = gap_length();
            nxt = 1'b0;
         end else begin
            nxt = 1'b1;
         end
         rsp_ready <= nxt;
      end
   end

   // One request transaction; valid stays up when no gap follows.
   task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic csr_write(csr_reg_type idx, logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Let the pipeline empty before touching registers or finishing.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (STAGES + 5) @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] random_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return COORD_W'($urandom);
      if (r < 9) return COORD_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      return COORD_W'(int'($urandom_range(0, 4)) - 2) <<< 16;
   endfunction

   initial begin
      logic signed [COORD_W-1:0] cmin;
      logic signed [COORD_W-1:0] cmax;
      logic [PERS_W-1:0] pers_set[6];
      logic scaled_set[6];
      cmin = {1'b1, {(COORD_W-1){1'b0}}};
      cmax = {1'b0, {(COORD_W-1){1'b1}}};
      pers_set   = '{PERS_W'(PERS_RESET), 0, 65536, 131071, 1, 49152};
      scaled_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      phase = 0;
      busy_burst = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points: extremes, lattice points, negative fractions.
      send_point(0, 0);
      send_point(cmin, cmin);
      send_point(cmax, cmax);
      send_point(cmin, cmax);
      send_point(cmax, cmin);
      send_point(-1, -1);
      send_point(1, 1);
      send_point(65536, 65536);
      send_point(-65536, 32768);
      send_point(-98304, -12345);
      send_point(32767, -32769);
      send_point(30'sh1000_0000, -30'sh1000_0000);
      drain();
      csr_write(REG_PERSISTENCE, 65536);
      csr_write(REG_SCALED_MODE, 0);
      send_point(-98304, -98304);
      send_point(cmax, 65535);
      send_point(-30'sd40000, 30'sd40000);
      send_point(cmin, 0);

      // Random phases across register settings, one with the long stall.
      for (int p = 0; p < 6; p++) begin
         drain();
         csr_write(REG_PERSISTENCE, CSR_DATA_W'(pers_set[p]));
         csr_write(REG_SCALED_MODE, CSR_DATA_W'(scaled_set[p]));
         phase = p + 1;
         busy_burst = (p == 3);
         for (int i = 0; i < 125; i++) send_point(random_coord(), random_coord());
      end
      busy_burst = 0;
      drain();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
